/* hw/rtl/emdc_pkg.sv */
// Shared types and constants for the encoder-matched drive controller.
// No dependencies; used by emdc_drive and encoder_matched_drive_controller.
package emdc_pkg;

  localparam int CountW   = 15;
  localparam int TimerW   = 16;
  localparam int PowerW   = 8;
  localparam int GoalW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [TimerW-1:0] TimerMax = '1;

  // Register indexes on the config channel
  typedef enum logic [CfgIdxW-1:0] {
    CFG_POWER_FLOOR    = 3'd0,
    CFG_POWER_CEIL     = 3'd1,
    CFG_MISMATCH_LIMIT = 3'd2,
    CFG_STOP_BAND      = 3'd3,
    CFG_SETTLE_MS      = 3'd4,
    CFG_TIMEOUT_MS     = 3'd5
  } cfg_index_t;

  // Reset values
  localparam logic [7:0]  PowerFloorRst    = 8'd145;
  localparam logic [7:0]  PowerCeilRst     = 8'd180;
  localparam logic [7:0]  MismatchLimitRst = 8'd5;
  localparam logic [7:0]  StopBandRst      = 8'd15;
  localparam logic [15:0] SettleMsRst      = 16'd500;
  localparam logic [15:0] TimeoutMsRst     = 16'd2000;

  typedef struct packed {
    logic [7:0]  power_floor;
    logic [7:0]  power_ceiling;
    logic [7:0]  mismatch_limit;
    logic [7:0]  stop_band;
    logic [15:0] settle_ms;
    logic [15:0] timeout_ms;
  } cfg_t;

  // Drive law result for one evaluation
  typedef struct packed {
    logic [PowerW-1:0] left_power;
    logic [PowerW-1:0] right_power;
    logic              on_target;   // arrived and sides matched
  } drive_t;

endpackage

/* hw/rtl/emdc_drive.sv */
// Drive law: ramped, clamped motor power and side balancing from pulse counts.
// Depends on emdc_pkg (cfg_t, drive_t, widths).
module emdc_drive (
  input  logic [emdc_pkg::CountW-1:0]       left_count,
  input  logic [emdc_pkg::CountW-1:0]       right_count,
  input  logic signed [emdc_pkg::GoalW-1:0] goal,
  input  emdc_pkg::cfg_t                    cfg,
  output emdc_pkg::drive_t                  drive
);

  logic [15:0]        sum;
  logic [14:0]        avg;
  logic [14:0]        diff;
  logic [14:0]        maxc;
  logic               left_lead;
  logic signed [16:0] goal_x;
  logic [16:0]        abs_goal;
  logic signed [16:0] goal_adj;
  logic signed [16:0] half_goal;
  logic signed [16:0] avg_s;
  logic               arrived;
  logic               mismatch;
  logic signed [21:0] ramp;
  logic signed [21:0] pw;
  logic signed [21:0] pw_hi;
  logic signed [21:0] min_s;
  logic signed [21:0] max_s;
  logic [7:0]         pw_c;

  assign sum       = {1'b0, left_count} + {1'b0, right_count};
  assign avg       = sum[15:1];
  assign left_lead = left_count > right_count;
  assign diff      = left_lead ? (left_count - right_count) : (right_count - left_count);
  assign maxc      = left_lead ? left_count : right_count;

  assign goal_x   = {goal[15], goal};
  assign abs_goal = goal[15] ? 17'(-goal_x) : 17'(goal_x);
  // truncate toward zero on halving
  assign goal_adj  = goal_x + $signed({16'b0, goal[15]});
  assign half_goal = goal_adj >>> 1;
  assign avg_s     = $signed({2'b0, avg});

  assign arrived  = {2'b0, maxc} >= abs_goal;
  assign mismatch = diff > {7'b0, cfg.mismatch_limit};

  assign min_s = $signed({14'b0, cfg.power_floor});
  assign max_s = $signed({14'b0, cfg.power_ceiling});

  always_comb begin
    if (avg_s > half_goal) begin
      ramp = $signed({{6{goal[15]}}, goal}) - $signed({3'b0, avg, 4'b0});
    end else begin
      ramp = $signed({5'b0, avg, 2'b0});
    end
    pw    = ramp + min_s;
    pw_hi = (pw > max_s) ? max_s : pw;
    pw_c  = (pw_hi < min_s) ? cfg.power_floor : pw_hi[7:0];
  end

  always_comb begin
    drive.left_power  = '0;
    drive.right_power = '0;
    drive.on_target   = arrived && !mismatch;
    if (!arrived) begin
      if (mismatch) begin
        if (left_lead) drive.left_power = pw_c;
        else           drive.right_power = pw_c;
      end else begin
        drive.left_power  = pw_c;
        drive.right_power = pw_c;
      end
    end else if (diff >= {7'b0, cfg.stop_band}) begin
      // residual correction after arrival
      if (left_lead) drive.left_power = cfg.power_floor;
      else           drive.right_power = cfg.power_floor;
    end
  end

endmodule

/* hw/rtl/encoder_matched_drive_controller.sv */
// Top level of the encoder-matched straight-drive controller.
// Depends on emdc_pkg and emdc_drive.
//
// Output: a result beat appears on m_* in the cycle after its input beat is taken.
// Throughput: one beat per cycle unless m_tready stalls; the whole update (edge
//   count, timers, drive law) is one combinational pass into the output register.
// Reset (rst, synchronous): config returns to defaults, move idle, counts,
//   timers and goal zero, output register empty. No clearing pass.
module encoder_matched_drive_controller (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] target_pulses, [16] left_level,
                                 // [17] right_level, [18] ms_tick, [23:19] zero
  input  logic        s_tuser,   // [0] mode (0 sample, 1 start)
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] left_power, [15:8] right_power,
                                 // [16] forward, [17] moving,
                                 // [32:18] left_total, [47:33] right_total
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [emdc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [emdc_pkg::CfgDataW-1:0] cfg_data
);

  localparam int CW = emdc_pkg::CountW;
  localparam int TW = emdc_pkg::TimerW;

  // config registers
  emdc_pkg::cfg_t cfg;

  // move state
  logic          left_prev, right_prev;
  logic [CW-1:0] left_count, right_count;
  logic signed [15:0] goal;
  logic [TW-1:0] since_off_target, since_start;
  logic          active;

  // unpacked input beat
  logic               in_mode;
  logic signed [15:0] in_target;
  logic               in_left, in_right, in_tick;
  logic               accept;

  // next state
  logic [CW-1:0]      left_count_next, right_count_next;
  logic signed [15:0] goal_next;
  logic [TW-1:0]      sot_step, since_start_next, since_off_target_next;
  logic               active_step, active_next, end_move;

  emdc_pkg::drive_t drive;
  logic [7:0] left_power, right_power;

  assign in_target = $signed(s_tdata[15:0]);
  assign in_left   = s_tdata[16];
  assign in_right  = s_tdata[17];
  assign in_tick   = s_tdata[18];
  assign in_mode   = s_tuser;

  // output register frees up when its beat is taken
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // ---- config writes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_floor    <= emdc_pkg::PowerFloorRst;
      cfg.power_ceiling  <= emdc_pkg::PowerCeilRst;
      cfg.mismatch_limit <= emdc_pkg::MismatchLimitRst;
      cfg.stop_band      <= emdc_pkg::StopBandRst;
      cfg.settle_ms      <= emdc_pkg::SettleMsRst;
      cfg.timeout_ms     <= emdc_pkg::TimeoutMsRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        emdc_pkg::CFG_POWER_FLOOR:    cfg.power_floor    <= cfg_data[7:0];
        emdc_pkg::CFG_POWER_CEIL:     cfg.power_ceiling  <= cfg_data[7:0];
        emdc_pkg::CFG_MISMATCH_LIMIT: cfg.mismatch_limit <= cfg_data[7:0];
        emdc_pkg::CFG_STOP_BAND:      cfg.stop_band      <= cfg_data[7:0];
        emdc_pkg::CFG_SETTLE_MS:      cfg.settle_ms      <= cfg_data;
        emdc_pkg::CFG_TIMEOUT_MS:     cfg.timeout_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- count / timer step ----
  // Start loads the goal and clears everything; a sample during a move counts
  // rising edges and ticks the timers. Both saturate.
  always_comb begin
    goal_next        = goal;
    left_count_next  = left_count;
    right_count_next = right_count;
    sot_step         = since_off_target;
    since_start_next = since_start;
    active_step      = active;
    if (in_mode) begin
      goal_next        = in_target;
      left_count_next  = '0;
      right_count_next = '0;
      sot_step         = '0;
      since_start_next = '0;
      active_step      = 1'b1;
    end else if (active) begin
      if (in_left && !left_prev && left_count != emdc_pkg::CountMax)
        left_count_next = left_count + CW'(1);
      if (in_right && !right_prev && right_count != emdc_pkg::CountMax)
        right_count_next = right_count + CW'(1);
      if (in_tick) begin
        if (since_off_target != emdc_pkg::TimerMax) sot_step = since_off_target + TW'(1);
        if (since_start != emdc_pkg::TimerMax) since_start_next = since_start + TW'(1);
      end
    end
  end

  emdc_drive u_drive (
    .left_count  (left_count_next),
    .right_count (right_count_next),
    .goal        (goal_next),
    .cfg         (cfg),
    .drive       (drive)
  );

  // ---- end of move and settle timer ----
  assign end_move = active_step &&
                    (sot_step >= cfg.settle_ms || since_start_next >= cfg.timeout_ms);
  assign active_next = active_step && !end_move;
  // settle timer restarts whenever the move is off target
  assign since_off_target_next = (active_next && !drive.on_target) ? '0 : sot_step;
  assign left_power  = active_next ? drive.left_power  : '0;
  assign right_power = active_next ? drive.right_power : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_prev        <= 1'b0;
      right_prev       <= 1'b0;
      left_count       <= '0;
      right_count      <= '0;
      goal             <= '0;
      since_off_target <= '0;
      since_start      <= '0;
      active           <= 1'b0;
    end else if (accept) begin
      left_prev        <= in_left;
      right_prev       <= in_right;
      left_count       <= left_count_next;
      right_count      <= right_count_next;
      goal             <= goal_next;
      since_off_target <= since_off_target_next;
      since_start      <= since_start_next;
      active           <= active_next;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {right_count_next, left_count_next, active_next, !goal_next[15],
                  right_power, left_power};
    end
  end

  // ---- assertions ----
  logic [14:0] out_diff;
  assign out_diff = (m_tdata[32:18] > m_tdata[47:33]) ? (m_tdata[32:18] - m_tdata[47:33])
                                                      : (m_tdata[47:33] - m_tdata[32:18]);

  a_idle_no_power: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[17]) |-> (m_tdata[15:0] == 16'd0))
    else $error("power driven while no move is active");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_mode) |=> (left_count == '0 && right_count == '0 && since_start == '0))
    else $error("start beat did not clear counts and timer");

  a_power_floor: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[7:0] != 8'd0 || m_tdata[15:8] != 8'd0)) |->
    ((m_tdata[7:0] == 8'd0 || m_tdata[7:0] >= cfg.power_floor) &&
     (m_tdata[15:8] == 8'd0 || m_tdata[15:8] >= cfg.power_floor)))
    else $error("driven power below the power floor");

  a_both_sides_matched: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7:0] != 8'd0 && m_tdata[15:8] != 8'd0) |->
    (out_diff <= {7'b0, cfg.mismatch_limit}))
    else $error("both sides driven while mismatched");

  a_idle_holds_timer: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_mode && !active) |=> $stable(since_start))
    else $error("timer moved while idle");

endmodule

/* sim/tb_encoder_matched_drive_controller.sv */
// Self-checking testbench for encoder_matched_drive_controller: streams command
// beats, predicts every result beat in SystemVerilog and compares it.
// Depends on emdc_pkg and the controller RTL only.
module tb_encoder_matched_drive_controller;
  timeunit 1ns;
  timeprecision 1ps;

  // Command beat as carried on s_tdata (mode travels on s_tuser)
  typedef struct packed {
    logic [4:0]         pad;
    logic               ms_tick;
    logic               right_level;
    logic               left_level;
    logic signed [15:0] target_pulses;
  } drive_cmd_t;

  // Result beat as carried on m_tdata, lowest field last
  typedef struct packed {
    logic [14:0] right_total;
    logic [14:0] left_total;
    logic        moving;
    logic        forward;
    logic [7:0]  right_power;
    logic [7:0]  left_power;
  } drive_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [15:0] target_pulses, [16] left_level, [17] right_level,
                          // [18] ms_tick, [23:19] zero
  logic        s_tuser;   // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;   // [7:0] left_power, [15:8] right_power, [16] forward,
                          // [17] moving, [32:18] left_total, [47:33] right_total
  logic        cfg_valid;
  logic        cfg_ready;
  logic [emdc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [emdc_pkg::CfgDataW-1:0] cfg_data;

  encoder_matched_drive_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register copy and move state, kept apart from the DUT
  // ---------------------------------------------------------------------------
  emdc_pkg::cfg_t drive_cfg;
  logic        lvl_l_prev, lvl_r_prev;
  logic [14:0] cnt_l, cnt_r;
  int          goal_pulses;
  logic [15:0] on_target_ms, move_ms;
  logic        in_move;

  drive_result_t expected_q[$];
  drive_result_t want_beat, got_beat;

  // Knobs shared between the stimulus tasks and the receiver process
  int src_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold      = 0;   // forced back-to-back stall cycles on m_tready

  int fail_count     = 0;
  int mismatch_shown = 0;
  int commands_taken = 0;
  int results_seen   = 0;
  int moves_started  = 0;

  // One command beat through the control law: edge count, timers, end test,
  // then the drive decision on the updated counts.
  function automatic drive_result_t predict_drive(input logic start, input drive_cmd_t c);
    int l, r, diff, peak, avg, ramp, pw, goal_mag;
    logic mismatch, arrived;
    drive_result_t res;
    if (start) begin
      goal_pulses  = int'(c.target_pulses);
      cnt_l        = '0;
      cnt_r        = '0;
      on_target_ms = '0;
      move_ms      = '0;
      in_move      = 1'b1;
    end else if (in_move) begin
      if (c.left_level && !lvl_l_prev && cnt_l < emdc_pkg::CountMax) cnt_l++;
      if (c.right_level && !lvl_r_prev && cnt_r < emdc_pkg::CountMax) cnt_r++;
      if (c.ms_tick) begin
        if (on_target_ms < emdc_pkg::TimerMax) on_target_ms++;
        if (move_ms < emdc_pkg::TimerMax) move_ms++;
      end
    end
    // levels are tracked even when idle
    lvl_l_prev = c.left_level;
    lvl_r_prev = c.right_level;

    res      = '0;
    l        = int'(cnt_l);
    r        = int'(cnt_r);
    diff     = (l > r) ? l - r : r - l;
    peak     = (l > r) ? l : r;
    goal_mag = (goal_pulses < 0) ? -goal_pulses : goal_pulses;
    mismatch = diff > int'(drive_cfg.mismatch_limit);
    arrived  = peak >= goal_mag;

    if (in_move) begin
      if (on_target_ms >= drive_cfg.settle_ms || move_ms >= drive_cfg.timeout_ms) begin
        in_move = 1'b0;   // ending beat drives nothing
      end else begin
        if (!arrived || mismatch) on_target_ms = '0;
        // ramp up on 4*avg, ramp down past half the goal; int division truncates
        avg  = (l + r) / 2;
        ramp = (avg > goal_pulses / 2) ? goal_pulses - 16 * avg : 4 * avg;
        pw   = int'(drive_cfg.power_floor) + ramp;
        if (pw > int'(drive_cfg.power_ceiling)) pw = int'(drive_cfg.power_ceiling);
        if (pw < int'(drive_cfg.power_floor)) pw = int'(drive_cfg.power_floor);
        if (!arrived) begin
          if (mismatch) begin
            // only the leading side keeps power
            if (l > r) res.left_power = pw[7:0];
            else res.right_power = pw[7:0];
          end else begin
            res.left_power  = pw[7:0];
            res.right_power = pw[7:0];
          end
        end else if (diff >= int'(drive_cfg.stop_band)) begin
          // residual correction after arrival; ties go to the right side
          if (l > r) res.left_power = drive_cfg.power_floor;
          else res.right_power = drive_cfg.power_floor;
        end
      end
    end
    res.forward     = goal_pulses >= 0;
    res.moving      = in_move;
    res.left_total  = cnt_l;
    res.right_total = cnt_r;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: check the result beat, then predict from the command beat.
  // Results are registered, so a result never belongs to this edge's command.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got_beat = drive_result_t'(m_tdata);
        if (expected_q.size() == 0) begin
          fail_count++;
          if (mismatch_shown < 10) begin
            mismatch_shown++;
            $display("%0t: result beat with nothing expected: %h", $realtime, m_tdata);
          end
        end else begin
          want_beat = expected_q.pop_front();
          if (got_beat !== want_beat) begin
            fail_count++;
            if (mismatch_shown < 10) begin
              mismatch_shown++;
              $display("%0t: result %0d differs", $realtime, results_seen);
              $display("  want lp=%0d rp=%0d fwd=%b mov=%b lt=%0d rt=%0d",
                       want_beat.left_power, want_beat.right_power, want_beat.forward,
                       want_beat.moving, want_beat.left_total, want_beat.right_total);
              $display("  got  lp=%0d rp=%0d fwd=%b mov=%b lt=%0d rt=%0d",
                       got_beat.left_power, got_beat.right_power, got_beat.forward,
                       got_beat.moving, got_beat.left_total, got_beat.right_total);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        commands_taken++;
        if (s_tuser) moves_started++;
        expected_q.push_back(predict_drive(s_tuser, drive_cmd_t'(s_tdata)));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          emdc_pkg::CFG_POWER_FLOOR:    drive_cfg.power_floor    = cfg_data[7:0];
          emdc_pkg::CFG_POWER_CEIL:     drive_cfg.power_ceiling  = cfg_data[7:0];
          emdc_pkg::CFG_MISMATCH_LIMIT: drive_cfg.mismatch_limit = cfg_data[7:0];
          emdc_pkg::CFG_STOP_BAND:      drive_cfg.stop_band      = cfg_data[7:0];
          emdc_pkg::CFG_SETTLE_MS:      drive_cfg.settle_ms      = cfg_data;
          emdc_pkg::CFG_TIMEOUT_MS:     drive_cfg.timeout_ms     = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stalls, or a forced hold-off counted down here
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // Offer one command beat after a random gap and hold it until taken
  task automatic send_item(input logic start, input logic [15:0] tgt,
                           input logic ll, input logic rl, input logic tick);
    drive_cmd_t cmd;
    int gap;
    cmd = '{pad: '0, ms_tick: tick, right_level: rl, left_level: ll, target_pulses: tgt};
    gap = 0;
    while (gap < 30 && $urandom_range(99) < src_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cmd;
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result beat has arrived
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);   // output register margin
  endtask

  task automatic write_reg(input emdc_pkg::cfg_index_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Full register set, written only with the block idle. Byte-wide registers
  // get junk in the upper byte, which must be dropped.
  task automatic program_regs(input logic [7:0] min_pw, input logic [7:0] max_pw,
                              input logic [7:0] mis_lim, input logic [7:0] band,
                              input logic [15:0] settle, input logic [15:0] tmo);
    wait_drained();
    write_reg(emdc_pkg::CFG_POWER_FLOOR,    {8'($urandom), min_pw});
    write_reg(emdc_pkg::CFG_POWER_CEIL,     {8'($urandom), max_pw});
    write_reg(emdc_pkg::CFG_MISMATCH_LIMIT, {8'($urandom), mis_lim});
    write_reg(emdc_pkg::CFG_STOP_BAND,      {8'($urandom), band});
    write_reg(emdc_pkg::CFG_SETTLE_MS,      settle);
    write_reg(emdc_pkg::CFG_TIMEOUT_MS,     tmo);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked beats: goal extremes, idle behavior, zero timers, inverted
  // power bounds and the tie rule after arrival.
  task automatic test_directed_cases();
    src_idle_pct = 0;
    rx_stall_pct = 0;
    // reset register values
    send_item(1'b0, 16'h1234, 1'b1, 1'b1, 1'b1);   // idle: tick ignored, levels tracked
    send_item(1'b1, 16'h7FFF, 1'b1, 1'b0, 1'b1);   // largest goal, left level latched
    send_item(1'b0, 16'h0000, 1'b1, 1'b1, 1'b1);   // right edge only
    send_item(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_item(1'b0, 16'h0000, 1'b1, 1'b0, 1'b1);   // left edge
    send_item(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_item(1'b1, 16'h8000, 1'b0, 1'b0, 1'b0);   // most negative goal, reverse
    send_item(1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send_item(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0);
    send_item(1'b0, 16'h0000, 1'b1, 1'b0, 1'b0);
    send_item(1'b1, 16'h0000, 1'b0, 1'b0, 1'b0);   // zero goal: arrived at once
    send_item(1'b0, 16'h0000, 1'b1, 1'b0, 1'b1);

    // all-zero registers: the start beat itself ends the move
    program_regs(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    send_item(1'b1, 16'd50, 1'b0, 1'b0, 1'b0);
    send_item(1'b0, 16'd0, 1'b1, 1'b1, 1'b1);

    // min above max, zero stop band and mismatch limit
    program_regs(8'd200, 8'd100, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF);
    send_item(1'b1, 16'd0, 1'b0, 1'b0, 1'b0);      // equal counts: right gets min
    send_item(1'b0, 16'd0, 1'b1, 1'b0, 1'b0);      // left leads after arrival
    send_item(1'b1, 16'd100, 1'b0, 1'b0, 1'b0);    // power pinned to min
    send_item(1'b0, 16'd0, 1'b0, 1'b1, 1'b0);      // right leads, left cut
    send_item(1'b0, 16'd0, 1'b1, 1'b1, 1'b0);
    send_item(1'b1, 16'hFFFD, 1'b0, 1'b0, 1'b0);   // short reverse move
    send_item(1'b0, 16'd0, 1'b1, 1'b1, 1'b0);
    send_item(1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
    send_item(1'b0, 16'd0, 1'b1, 1'b1, 1'b0);
  endtask

  // Well-formed moves with random goals, edge rates and tick rates, with a
  // sprinkle of fully random beats.
  task automatic test_random_moves(input int src_pct, input int rx_pct, input int n_items);
    int sent, len, pl, pr, tick_pct, k;
    logic ll, rl;
    logic [15:0] tgt;
    src_idle_pct = src_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    ll   = 1'b0;
    rl   = 1'b0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       tgt = 16'($urandom);
        1, 2:    tgt = 16'($urandom_range(10));
        default: tgt = 16'($urandom_range(60));
      endcase
      if ($urandom_range(3) == 0) tgt = -tgt;
      send_item(1'b1, tgt, ll, rl, 1'($urandom));
      sent++;
      len      = $urandom_range(20, 200);
      pl       = $urandom_range(20, 60);
      pr       = ($urandom_range(2) == 0) ? $urandom_range(5, 60) : pl;
      tick_pct = $urandom_range(10, 40);
      for (k = 0; k < len && sent < n_items; k++) begin
        if ($urandom_range(19) == 0) begin
          send_item(1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          if ($urandom_range(99) < pl) ll = ~ll;
          if ($urandom_range(99) < pr) rl = ~rl;
          send_item(1'b0, 16'($urandom), ll, rl, $urandom_range(99) < tick_pct);
        end
        sent++;
      end
    end
  endtask

  // Long receiver hold-off while beats keep coming: input must back up
  task automatic test_receiver_hold();
    int k;
    src_idle_pct = 0;
    rx_stall_pct = 0;
    send_item(1'b1, 16'd40, 1'b0, 1'b0, 1'b0);
    rx_hold = 300;
    for (k = 0; k < 60; k++)
      send_item(1'b0, 16'($urandom), k[1], k[0], 1'($urandom));
  endtask

  // Sender stops mid-move until all results are back, then carries on
  task automatic test_sender_drain();
    int k;
    src_idle_pct = 10;
    rx_stall_pct = 30;
    send_item(1'b1, 16'd30, 1'b0, 1'b0, 1'b0);
    for (k = 0; k < 25; k++)
      send_item(1'b0, 16'($urandom), k[0], k[1], $urandom_range(3) == 0);
    wait_drained();
    for (k = 0; k < 25; k++)
      send_item(1'b0, 16'($urandom), k[0], k[1], $urandom_range(3) == 0);
  endtask

  // All registers at their top values during a long-goal move
  task automatic test_top_registers();
    int k;
    program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    src_idle_pct = 0;
    rx_stall_pct = 0;
    send_item(1'b1, 16'h7FFF, 1'b0, 1'b0, 1'b0);
    for (k = 0; k < 40; k++)
      send_item(1'b0, 16'($urandom), k[0], k[0], 1'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    // predictor matches the block's reset state
    drive_cfg    = '{emdc_pkg::PowerFloorRst, emdc_pkg::PowerCeilRst,
                     emdc_pkg::MismatchLimitRst, emdc_pkg::StopBandRst,
                     emdc_pkg::SettleMsRst, emdc_pkg::TimeoutMsRst};
    lvl_l_prev   = 1'b0;
    lvl_r_prev   = 1'b0;
    cnt_l        = '0;
    cnt_r        = '0;
    goal_pulses  = 0;
    on_target_ms = '0;
    move_ms      = '0;
    in_move      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();

    // three idle profiles, each under its own register setting
    program_regs(8'd60, 8'd200, 8'd3, 8'd2, 16'd8, 16'd100);
    test_random_moves(10, 75, 480);
    program_regs(8'd145, 8'd180, 8'd5, 8'd15, 16'd4, 16'd60);
    test_random_moves(75, 10, 480);
    program_regs(8'd10, 8'd255, 8'd0, 8'd0, 16'd2, 16'd300);
    test_random_moves(0, 0, 480);

    test_receiver_hold();
    test_sender_drain();
    test_top_registers();

    wait_drained();
    $display("Covered %0d command beats, %0d move starts and %0d result beats,",
             commands_taken, moves_started, results_seen);
    $display("including backpressure, mid-move pauses and edge register settings.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d result beats failed", fail_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
